// ===== rtl/rcs_pkg.sv =====
// Shared constants and types for the RC stick command shaper.
// No dependencies; imported by rc_stick_command_shaper_unit.
package rcs_pkg;

   // Pulse geometry, in microseconds
   localparam logic [11:0] PULSE_CENTER = 12'd1500;
   localparam logic [8:0]  STICK_SPAN   = 9'd500;
   localparam logic [11:0] THR_BASE     = 12'd1000;
   localparam logic [9:0]  THR_SPAN     = 10'd1000;

   // Deadband handling, Q0.16
   localparam logic [15:0] DB_LIMIT = 16'd62259;
   localparam logic [6:0]  DB_SCALE = 7'd125;

   // Register reset values
   localparam logic [15:0] STICK_DB_RESET  = 16'd3277;
   localparam logic [15:0] THR_DB_RESET    = 16'd3277;
   localparam logic [15:0] MAX_ANGLE_RESET = 16'd7680;
   localparam logic [15:0] MAX_YAW_RESET   = 16'd2880;

   // Reciprocal divider: floor(2^40 / den), one quotient bit per step
   localparam logic [5:0] DIV_LAST = 6'd40;

   localparam int unsigned STICK_LANES = 3;
   localparam int unsigned YAW_LANE    = 2;

   typedef enum logic [1:0] {
      CSR_STICK_DB  = 2'd0,
      CSR_THR_DB    = 2'd1,
      CSR_MAX_ANGLE = 2'd2,
      CSR_MAX_YAW   = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      CAL_LOAD,
      CAL_DIV,
      CAL_SQUARE,
      CAL_DONE
   } cal_state_type;

endpackage

// ===== rtl/rc_stick_command_shaper_unit.sv =====
// RC stick command shaper: deadband, throttle curve and target scaling.
// Seven-stage pipeline plus a reciprocal calibration sequencer; uses rcs_pkg.
//
//   channel | direction | beat contents
//   req_    | in        | four 12-bit pulse widths
//   rsp_    | out       | three sticks, throttle level, three targets
//   csr_    | in        | register writes, four 16-bit registers
//
// One beat per cycle sustained while rsp_tready stays high and calibration
// is done; each beat passes the seven register stages of the datapath.
// After reset and after every register write, req_tready stays low during
// calibration: load of the deadband terms, 41 divider steps, a squaring step.
// Bubbles collapse on a stall; a held rsp_ beat keeps its data.
module rc_stick_command_shaper_unit
   import rcs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,

   input  logic         req_tvalid,
   output logic         req_tready,
   // roll_pulse[11:0], pitch_pulse[23:12], throttle_pulse[35:24], yaw_pulse[47:36]
   input  logic [47:0]  req_tdata,

   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // roll_cmd[15:0], pitch_cmd[31:16], yaw_cmd[47:32],
   // throttle_level[62:48], roll_angle_cmd[79:63], pitch_angle_cmd[96:80],
   // yaw_rate_cmd[113:97], zero fill[119:114]
   output logic [119:0] rsp_tdata,

   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_wdata
);

   localparam int unsigned NUM_STAGES = 7;
   localparam logic [42:0] STICK_HALF = 43'd1 << 23;
   localparam logic [49:0] THR_HALF   = 50'd1 << 33;
   localparam logic [30:0] TGT_HALF   = 31'd8192;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [15:0] stick_db_ff, thr_db_ff, max_angle_ff, max_yaw_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stick_db_ff  <= STICK_DB_RESET;
         thr_db_ff    <= THR_DB_RESET;
         max_angle_ff <= MAX_ANGLE_RESET;
         max_yaw_ff   <= MAX_YAW_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_STICK_DB:  stick_db_ff  <= csr_wdata;
            CSR_THR_DB:    thr_db_ff    <= csr_wdata;
            CSR_MAX_ANGLE: max_angle_ff <= csr_wdata;
            CSR_MAX_YAW:   max_yaw_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Calibration: offsets, denominators, reciprocals, squared denominator
   // ------------------------------------------------------------------
   cal_state_type cal_state_ff, cal_state_in;
   logic          cal_done;

   logic [22:0] off_s_ff, off_t_ff;
   logic [22:0] den_s_ff, den_t_ff;
   logic [22:0] rem_s_ff, rem_t_ff;
   logic [21:0] quot_s_ff, quot_t_ff;
   logic [5:0]  div_cnt_ff;
   logic [45:0] dsq_ff;

   logic [15:0] db_s_clamp, db_t_clamp;
   logic [16:0] span_s, span_t;
   logic [23:0] den_s_full, den_t_full;
   logic [22:0] off_s_in, off_t_in;
   logic        div_bit;
   logic [23:0] rem_sh_s, rem_sh_t;
   logic        ge_s, ge_t;
   logic [23:0] rem_sub_s, rem_sub_t;

   always_comb begin
      db_s_clamp = (stick_db_ff > DB_LIMIT) ? DB_LIMIT : stick_db_ff;
      db_t_clamp = (thr_db_ff > DB_LIMIT) ? DB_LIMIT : thr_db_ff;
      span_s     = 17'h10000 - {1'b0, db_s_clamp};
      span_t     = 17'h10000 - {1'b0, db_t_clamp};
      den_s_full = span_s * DB_SCALE;
      den_t_full = span_t * DB_SCALE;
      off_s_in   = db_s_clamp * DB_SCALE;
      off_t_in   = db_t_clamp * DB_SCALE;
      // dividend is 2^40: its only set bit enters on the first step
      div_bit    = (div_cnt_ff == 6'd0);
      rem_sh_s   = {rem_s_ff, div_bit};
      rem_sh_t   = {rem_t_ff, div_bit};
      ge_s       = rem_sh_s >= {1'b0, den_s_ff};
      ge_t       = rem_sh_t >= {1'b0, den_t_ff};
      rem_sub_s  = rem_sh_s - {1'b0, den_s_ff};
      rem_sub_t  = rem_sh_t - {1'b0, den_t_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_state_ff <= CAL_LOAD;
      end else begin
         cal_state_ff <= cal_state_in;
      end
   end

   always_comb begin
      cal_state_in = cal_state_ff;
      cal_done     = 1'b0;
      case (cal_state_ff)
         CAL_LOAD:   cal_state_in = CAL_DIV;
         CAL_DIV:    cal_state_in = (div_cnt_ff == DIV_LAST) ? CAL_SQUARE : CAL_DIV;
         CAL_SQUARE: cal_state_in = CAL_DONE;
         CAL_DONE:   cal_done     = 1'b1;
         default:    cal_state_in = CAL_LOAD;
      endcase
      // any write restarts the sequence
      if (csr_we) begin
         cal_state_in = CAL_LOAD;
      end
   end

   always_ff @(posedge clock) begin
      case (cal_state_ff)
         CAL_LOAD: begin
            off_s_ff   <= off_s_in;
            off_t_ff   <= off_t_in;
            den_s_ff   <= den_s_full[22:0];
            den_t_ff   <= den_t_full[22:0];
            rem_s_ff   <= '0;
            rem_t_ff   <= '0;
            quot_s_ff  <= '0;
            quot_t_ff  <= '0;
            div_cnt_ff <= '0;
         end
         CAL_DIV: begin
            rem_s_ff   <= ge_s ? rem_sub_s[22:0] : rem_sh_s[22:0];
            rem_t_ff   <= ge_t ? rem_sub_t[22:0] : rem_sh_t[22:0];
            quot_s_ff  <= {quot_s_ff[20:0], ge_s};
            quot_t_ff  <= {quot_t_ff[20:0], ge_t};
            div_cnt_ff <= div_cnt_ff + 6'd1;
         end
         CAL_SQUARE: begin
            dsq_ff <= den_t_ff * den_t_ff;
         end
         default: ;
      endcase
   end

   // stick path uses floor(2^38 / den)
   logic [19:0] recip_s;
   assign recip_s = quot_s_ff[21:2];

   // ------------------------------------------------------------------
   // Pipeline flow control
   // ------------------------------------------------------------------
   logic [NUM_STAGES-1:0] stage_valid_ff;
   logic [NUM_STAGES-1:0] stage_en;
   logic                  req_accept;

   always_comb begin
      stage_en[NUM_STAGES-1] = !stage_valid_ff[NUM_STAGES-1] || rsp_tready;
      for (int s = NUM_STAGES - 2; s >= 0; s--) begin
         stage_en[s] = !stage_valid_ff[s] || stage_en[s+1];
      end
   end

   assign req_tready = stage_en[0] && cal_done;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = stage_valid_ff[NUM_STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
      end else begin
         if (stage_en[0]) begin
            stage_valid_ff[0] <= req_accept;
         end
         for (int s = 1; s < NUM_STAGES; s++) begin
            if (stage_en[s]) begin
               stage_valid_ff[s] <= stage_valid_ff[s-1];
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: center, clamp, subtract deadband offset
   // ------------------------------------------------------------------
   logic [11:0] stick_pulse [STICK_LANES];
   logic [11:0] thr_pulse;

   assign stick_pulse[0] = req_tdata[11:0];
   assign stick_pulse[1] = req_tdata[23:12];
   assign stick_pulse[2] = req_tdata[47:36];
   assign thr_pulse      = req_tdata[35:24];

   logic [22:0] s1_num_in  [STICK_LANES];
   logic        s1_zero_in [STICK_LANES];
   logic        s1_neg_in  [STICK_LANES];
   logic [22:0] s1_tnum_in;
   logic        s1_tzero_in;

   always_comb begin
      logic [11:0] dev;
      logic [8:0]  mag_c;
      logic [22:0] scaled;
      logic [11:0] tdev;
      logic [9:0]  t_c;
      logic [22:0] tscaled;
      for (int j = 0; j < STICK_LANES; j++) begin
         s1_neg_in[j]  = stick_pulse[j] < PULSE_CENTER;
         dev           = s1_neg_in[j] ? (PULSE_CENTER - stick_pulse[j])
                                      : (stick_pulse[j] - PULSE_CENTER);
         mag_c         = (dev > {3'b0, STICK_SPAN}) ? STICK_SPAN : dev[8:0];
         scaled        = {mag_c, 14'b0};
         s1_zero_in[j] = scaled <= off_s_ff;
         s1_num_in[j]  = scaled - off_s_ff;
      end
      tdev        = (thr_pulse < THR_BASE) ? 12'd0 : (thr_pulse - THR_BASE);
      t_c         = (tdev > {2'b0, THR_SPAN}) ? THR_SPAN : tdev[9:0];
      tscaled     = {t_c, 13'b0};
      s1_tzero_in = tscaled <= off_t_ff;
      s1_tnum_in  = tscaled - off_t_ff;
   end

   logic [22:0] s1_num_ff  [STICK_LANES];
   logic        s1_zero_ff [STICK_LANES];
   logic        s1_neg_ff  [STICK_LANES];
   logic [22:0] s1_tnum_ff;
   logic        s1_tzero_ff;

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         s1_num_ff   <= s1_num_in;
         s1_zero_ff  <= s1_zero_in;
         s1_neg_ff   <= s1_neg_in;
         s1_tnum_ff  <= s1_tnum_in;
         s1_tzero_ff <= s1_tzero_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: multiply by reciprocal
   // ------------------------------------------------------------------
   logic [42:0] s2_prod_ff [STICK_LANES];
   logic [22:0] s2_num_ff  [STICK_LANES];
   logic        s2_zero_ff [STICK_LANES];
   logic        s2_neg_ff  [STICK_LANES];
   logic [44:0] s2_tprod_ff;
   logic [22:0] s2_tnum_ff;
   logic        s2_tzero_ff;

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         for (int j = 0; j < STICK_LANES; j++) begin
            s2_prod_ff[j] <= s1_num_ff[j] * recip_s;
         end
         s2_num_ff   <= s1_num_ff;
         s2_zero_ff  <= s1_zero_ff;
         s2_neg_ff   <= s1_neg_ff;
         s2_tprod_ff <= s1_tnum_ff * quot_t_ff;
         s2_tnum_ff  <= s1_tnum_ff;
         s2_tzero_ff <= s1_tzero_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: stick quotient estimate; throttle squares
   // ------------------------------------------------------------------
   logic [14:0] s3_qest_in [STICK_LANES];
   logic [24:0] s3_w;

   always_comb begin
      logic [42:0] rsum;
      for (int j = 0; j < STICK_LANES; j++) begin
         rsum          = s2_prod_ff[j] + STICK_HALF;
         s3_qest_in[j] = rsum[38:24];
      end
      s3_w = s2_tprod_ff[40:16];
   end

   logic [14:0] s3_qest_ff [STICK_LANES];
   logic [22:0] s3_num_ff  [STICK_LANES];
   logic        s3_zero_ff [STICK_LANES];
   logic        s3_neg_ff  [STICK_LANES];
   logic [49:0] s3_wsq_ff;
   logic [45:0] s3_tnumsq_ff;
   logic        s3_tzero_ff;

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         s3_qest_ff   <= s3_qest_in;
         s3_num_ff    <= s2_num_ff;
         s3_zero_ff   <= s2_zero_ff;
         s3_neg_ff    <= s2_neg_ff;
         s3_wsq_ff    <= s3_w * s3_w;
         s3_tnumsq_ff <= s2_tnum_ff * s2_tnum_ff;
         s3_tzero_ff  <= s2_tzero_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: stick rounding check product; throttle estimate
   // ------------------------------------------------------------------
   logic [14:0] s4_tqest_in;

   always_comb begin
      logic [49:0] tsum;
      tsum        = s3_wsq_ff + THR_HALF;
      s4_tqest_in = tsum[48:34];
   end

   logic [38:0] s4_chk_ff  [STICK_LANES];
   logic [14:0] s4_qest_ff [STICK_LANES];
   logic [22:0] s4_num_ff  [STICK_LANES];
   logic        s4_zero_ff [STICK_LANES];
   logic        s4_neg_ff  [STICK_LANES];
   logic [14:0] s4_tqest_ff;
   logic [45:0] s4_tnumsq_ff;
   logic        s4_tzero_ff;

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         for (int j = 0; j < STICK_LANES; j++) begin
            s4_chk_ff[j] <= den_s_ff * {s3_qest_ff[j], 1'b1};
         end
         s4_qest_ff   <= s3_qest_ff;
         s4_num_ff    <= s3_num_ff;
         s4_zero_ff   <= s3_zero_ff;
         s4_neg_ff    <= s3_neg_ff;
         s4_tqest_ff  <= s4_tqest_in;
         s4_tnumsq_ff <= s3_tnumsq_ff;
         s4_tzero_ff  <= s3_tzero_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 5: stick magnitude; throttle check partial products
   // ------------------------------------------------------------------
   logic [14:0] s5_mag_in [STICK_LANES];

   always_comb begin
      logic up;
      for (int j = 0; j < STICK_LANES; j++) begin
         // bump the estimate when the next code still rounds below
         up           = s4_chk_ff[j] <= {1'b0, s4_num_ff[j], 15'b0};
         s5_mag_in[j] = s4_zero_ff[j] ? 15'd0 : (s4_qest_ff[j] + {14'b0, up});
      end
   end

   logic [14:0] s5_mag_ff [STICK_LANES];
   logic        s5_neg_ff [STICK_LANES];
   logic [39:0] s5_plo_ff;
   logic [37:0] s5_phi_ff;
   logic [14:0] s5_tqest_ff;
   logic [45:0] s5_tnumsq_ff;
   logic        s5_tzero_ff;

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         s5_mag_ff    <= s5_mag_in;
         s5_neg_ff    <= s4_neg_ff;
         s5_plo_ff    <= dsq_ff[23:0] * {s4_tqest_ff, 1'b1};
         s5_phi_ff    <= dsq_ff[45:24] * {s4_tqest_ff, 1'b1};
         s5_tqest_ff  <= s4_tqest_ff;
         s5_tnumsq_ff <= s4_tnumsq_ff;
         s5_tzero_ff  <= s4_tzero_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 6: target product; throttle level
   // ------------------------------------------------------------------
   logic [14:0] s6_level_in;

   always_comb begin
      logic [61:0] total;
      logic [61:0] lhs;
      logic        up;
      total       = {s5_phi_ff, 24'b0} + {22'b0, s5_plo_ff};
      lhs         = {1'b0, s5_tnumsq_ff, 15'b0};
      up          = total <= lhs;
      s6_level_in = s5_tzero_ff ? 15'd0 : (s5_tqest_ff + {14'b0, up});
   end

   logic [30:0] s6_tprod_ff [STICK_LANES];
   logic [14:0] s6_mag_ff   [STICK_LANES];
   logic        s6_neg_ff   [STICK_LANES];
   logic [14:0] s6_level_ff;

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         for (int j = 0; j < STICK_LANES; j++) begin
            s6_tprod_ff[j] <= s5_mag_ff[j] * ((j == YAW_LANE) ? max_yaw_ff : max_angle_ff);
         end
         s6_mag_ff   <= s5_mag_ff;
         s6_neg_ff   <= s5_neg_ff;
         s6_level_ff <= s6_level_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 7: round targets, apply sign; output register
   // ------------------------------------------------------------------
   logic signed [15:0] out_stick_in  [STICK_LANES];
   logic signed [16:0] out_target_in [STICK_LANES];

   always_comb begin
      logic [30:0] rsum;
      logic [15:0] smag;
      logic [16:0] tmag;
      for (int j = 0; j < STICK_LANES; j++) begin
         rsum             = s6_tprod_ff[j] + TGT_HALF;
         smag             = {1'b0, s6_mag_ff[j]};
         tmag             = {1'b0, rsum[29:14]};
         out_stick_in[j]  = s6_neg_ff[j] ? -smag : smag;
         out_target_in[j] = s6_neg_ff[j] ? -tmag : tmag;
      end
   end

   logic signed [15:0] out_stick_ff  [STICK_LANES];
   logic signed [16:0] out_target_ff [STICK_LANES];
   logic [14:0]        out_level_ff;

   always_ff @(posedge clock) begin
      if (stage_en[6]) begin
         out_stick_ff  <= out_stick_in;
         out_target_ff <= out_target_in;
         out_level_ff  <= s6_level_ff;
      end
   end

   assign rsp_tdata = {6'b0, out_target_ff[2], out_target_ff[1], out_target_ff[0],
                       out_level_ff, out_stick_ff[2], out_stick_ff[1], out_stick_ff[0]};

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_write_blocks_input: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> !req_tready)
      else $error("input taken during recalibration");

   a_div_remainder: assert property (@(posedge clock) disable iff (reset)
      (cal_state_ff == CAL_DIV) |-> (rem_s_ff < den_s_ff) && (rem_t_ff < den_t_ff))
      else $error("divider remainder not below divisor");

   a_zero_stick_zero_target: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (out_stick_ff[0] == 16'sd0) |-> (out_target_ff[0] == 17'sd0))
      else $error("roll target nonzero for centered stick");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (out_level_ff <= 15'd16384) &&
                     (out_stick_ff[2] <= 16'sd16384) && (out_stick_ff[2] >= -16'sd16384))
      else $error("shaped value beyond full scale");

endmodule

// ===== bench/rc_stick_command_shaper_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for rc_stick_command_shaper_unit: pulse frames in, shaped commands out.
// Predicts each command in fixed point from its own register copy; depends on rcs_pkg and the RTL.
module rc_stick_command_shaper_unit_tb;
   import rcs_pkg::*;

   typedef struct packed {
      logic signed [16:0] yaw_rate_cmd;
      logic signed [16:0] pitch_angle_cmd;
      logic signed [16:0] roll_angle_cmd;
      logic [14:0]        throttle_level;
      logic signed [15:0] yaw_cmd;
      logic signed [15:0] pitch_cmd;
      logic signed [15:0] roll_cmd;
   } shaped_command_type;

   typedef enum logic [1:0] {
      RX_ALWAYS,
      RX_COIN,
      RX_SPARSE,
      RX_PERIODIC
   } rx_pattern_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [47:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [119:0] rsp_tdata;
   logic         csr_we = 1'b0;
   logic [1:0]   csr_index = '0;
   logic [15:0]  csr_wdata = '0;

   // register copy for prediction
   logic [15:0] stick_db_q  = STICK_DB_RESET;
   logic [15:0] thr_db_q    = THR_DB_RESET;
   logic [15:0] angle_q     = MAX_ANGLE_RESET;
   logic [15:0] yaw_rate_q  = MAX_YAW_RESET;

   shaped_command_type pending_commands[$];
   int frames_sent     = 0;
   int commands_seen   = 0;
   int mismatches      = 0;
   int settings_used   = 0;

   rc_stick_command_shaper_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Signed Q14 stick after centering, clamp and deadband rescale.
   function automatic int stick_shape(input logic [11:0] pulse);
      longint unsigned m, d, num, den, mag;
      bit neg;
      neg = (pulse < 12'd1500);
      m = neg ? 1500 - pulse : pulse - 1500;
      if (m > 500) m = 500;
      d = (stick_db_q > DB_LIMIT) ? DB_LIMIT : stick_db_q;
      if (m * 65536 <= d * 500) return 0;
      num = m * 16384 - d * 125;
      den = 125 * (65536 - d);
      mag = (num * 16384 + den / 2) / den;
      return neg ? -int'(mag) : int'(mag);
   endfunction

   // Unsigned Q14 throttle: offset, clamp, cutoff, rescale, square.
   function automatic int throttle_curve(input logic [11:0] pulse);
      longint unsigned t, c, num, den;
      t = (pulse < 12'd1000) ? 0 : pulse - 1000;
      if (t > 1000) t = 1000;
      c = (thr_db_q > DB_LIMIT) ? DB_LIMIT : thr_db_q;
      if (t * 65536 <= c * 1000) return 0;
      num = t * 8192 - c * 125;
      den = 125 * (65536 - c);
      return int'((num * num * 16384 + (den * den) / 2) / (den * den));
   endfunction

   function automatic int target_scale(input int stick, input logic [15:0] gain);
      longint unsigned mag, r;
      mag = (stick < 0) ? -stick : stick;
      r = (mag * gain + 8192) >> 14;
      return (stick < 0) ? -int'(r) : int'(r);
   endfunction

   function automatic shaped_command_type command_predict(input logic [47:0] beat);
      shaped_command_type c;
      int roll, pitch, yaw;
      roll  = stick_shape(beat[11:0]);
      pitch = stick_shape(beat[23:12]);
      yaw   = stick_shape(beat[47:36]);
      c.roll_cmd        = roll[15:0];
      c.pitch_cmd       = pitch[15:0];
      c.yaw_cmd         = yaw[15:0];
      c.throttle_level  = 15'(throttle_curve(beat[35:24]));
      c.roll_angle_cmd  = 17'(target_scale(roll, angle_q));
      c.pitch_angle_cmd = 17'(target_scale(pitch, angle_q));
      c.yaw_rate_cmd    = 17'(target_scale(yaw, yaw_rate_q));
      return c;
   endfunction

   task automatic report_mismatch(input string field, input int got, input int want);
      mismatches++;
      $display("mismatch at %0t: %s got %0d, expected %0d (command %0d)",
               $time, field, got, want, commands_seen);
   endtask

   // Predict on each accepted request beat, check each accepted result beat.
   always @(posedge clock) begin
      shaped_command_type got, want;
      if (!reset && req_tvalid && req_tready)
         pending_commands.push_back(command_predict(req_tdata));
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_commands.size() == 0) begin
            report_mismatch("unexpected beat", 0, 0);
         end else begin
            got  = shaped_command_type'(rsp_tdata[113:0]);
            want = pending_commands.pop_front();
            if (got.roll_cmd !== want.roll_cmd)
               report_mismatch("roll_cmd", got.roll_cmd, want.roll_cmd);
            if (got.pitch_cmd !== want.pitch_cmd)
               report_mismatch("pitch_cmd", got.pitch_cmd, want.pitch_cmd);
            if (got.yaw_cmd !== want.yaw_cmd)
               report_mismatch("yaw_cmd", got.yaw_cmd, want.yaw_cmd);
            if (got.throttle_level !== want.throttle_level)
               report_mismatch("throttle_level", got.throttle_level, want.throttle_level);
            if (got.roll_angle_cmd !== want.roll_angle_cmd)
               report_mismatch("roll_angle_cmd", got.roll_angle_cmd, want.roll_angle_cmd);
            if (got.pitch_angle_cmd !== want.pitch_angle_cmd)
               report_mismatch("pitch_angle_cmd", got.pitch_angle_cmd,
                               want.pitch_angle_cmd);
            if (got.yaw_rate_cmd !== want.yaw_rate_cmd)
               report_mismatch("yaw_rate_cmd", got.yaw_rate_cmd, want.yaw_rate_cmd);
            if (rsp_tdata[119:114] !== 6'd0)
               report_mismatch("zero fill", rsp_tdata[119:114], 0);
         end
         commands_seen++;
      end
   end

   // Receiver back-pressure: switch to a randomly chosen pattern after each random hold.
   rx_pattern_type rx_pattern = RX_ALWAYS;
   int rx_left = 0;
   int rx_tick = 0;
   always @(posedge clock) begin
      if (rx_left == 0) begin
         rx_pattern = rx_pattern_type'($urandom_range(0, 3));
         rx_left = $urandom_range(4, 60);
      end else begin
         rx_left--;
      end
      rx_tick++;
      case (rx_pattern)
         RX_ALWAYS:   rsp_tready <= 1'b1;
         RX_COIN:     rsp_tready <= 1'($urandom_range(0, 1));
         RX_SPARSE:   rsp_tready <= ($urandom_range(0, 3) == 0);
         RX_PERIODIC: rsp_tready <= (rx_tick % 5 != 0);
         default:     rsp_tready <= 1'b1;
      endcase
   end

   // Hold one beat until taken; caller is at a rising edge.
   task automatic send_frame(input logic [11:0] roll, input logic [11:0] pitch,
                             input logic [11:0] throttle, input logic [11:0] yaw);
      req_tvalid <= 1'b1;
      req_tdata  <= {yaw, throttle, pitch, roll};
      do @(posedge clock); while (req_tready !== 1'b1);
      frames_sent++;
   endtask

   // Drop valid and wait for every command, then let the pipeline settle.
   task automatic wait_for_quiet();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_commands.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [15:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic configure(input logic [15:0] stick_db, input logic [15:0] thr_db,
                            input logic [15:0] angle, input logic [15:0] yaw_rate);
      write_register(CSR_STICK_DB, stick_db);
      write_register(CSR_THR_DB, thr_db);
      write_register(CSR_MAX_ANGLE, angle);
      write_register(CSR_MAX_YAW, yaw_rate);
      csr_we     <= 1'b0;
      stick_db_q <= stick_db;
      thr_db_q   <= thr_db;
      angle_q    <= angle;
      yaw_rate_q <= yaw_rate;
      settings_used++;
      @(posedge clock);
   endtask

   function automatic logic [11:0] random_pulse();
      case ($urandom_range(0, 9))
         0, 1:    return 12'($urandom_range(0, 4095));
         2:       return 12'($urandom_range(1440, 1560));
         3:       return 12'($urandom_range(970, 1120));
         default: return 12'($urandom_range(900, 2100));
      endcase
   endfunction

   function automatic logic [15:0] random_setting();
      case ($urandom_range(0, 7))
         0:       return 16'd0;
         1:       return 16'hFFFF;
         2:       return DB_LIMIT;
         3:       return DB_LIMIT + 16'd1;
         4, 5:    return 16'($urandom_range(0, 9000));
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic send_corner_frames();
      send_frame(12'd0, 12'd4095, 12'd0, 12'd1500);
      send_frame(12'd4095, 12'd0, 12'd4095, 12'd0);
      send_frame(12'd1000, 12'd2000, 12'd1000, 12'd2000);
      send_frame(12'd999, 12'd2001, 12'd2000, 12'd1001);
      send_frame(12'd1500, 12'd1500, 12'd2001, 12'd1500);
      send_frame(12'd1525, 12'd1475, 12'd1050, 12'd1526);
      send_frame(random_pulse(), random_pulse(), random_pulse(), random_pulse());
      send_frame(random_pulse(), random_pulse(), random_pulse(), random_pulse());
   endtask

   // Reset settings: full travel, clamps and both deadband edges.
   task automatic test_reset_defaults();
      send_corner_frames();
      send_frame(12'd1526, 12'd1474, 12'd1051, 12'd1474);
      send_frame(12'd1499, 12'd1501, 12'd999, 12'd1499);
      send_frame(12'd2000, 12'd1000, 12'd1500, 12'd1000);
      send_frame(12'd2500, 12'd500, 12'd3000, 12'd2048);
      send_frame(12'hAAA, 12'h555, 12'hAAA, 12'h555);
      send_frame(12'h555, 12'hAAA, 12'h555, 12'hAAA);
      wait_for_quiet();
   endtask

   // Zero, saturated and just-past-saturation deadbands with extreme gains.
   task automatic test_deadband_limits();
      configure(16'd0, 16'd0, 16'd0, 16'd0);
      send_corner_frames();
      wait_for_quiet();
      configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_corner_frames();
      wait_for_quiet();
      configure(DB_LIMIT, DB_LIMIT, 16'd1, 16'hFFFF);
      send_corner_frames();
      send_frame(12'd1976, 12'd1024, 12'd1951, 12'd1975);
      wait_for_quiet();
      configure(DB_LIMIT - 16'd1, DB_LIMIT + 16'd1, 16'hFFFF, 16'd1);
      send_corner_frames();
      send_frame(12'd1976, 12'd1024, 12'd1950, 12'd1975);
      wait_for_quiet();
   endtask

   // Random frames in bursts under random settings; drain between settings.
   task automatic test_random_traffic();
      int sent, burst, cap;
      for (int phase = 0; phase < 6; phase++) begin
         configure(random_setting(), random_setting(), random_setting(), random_setting());
         sent = 0;
         while (sent < 115) begin
            cap = ($urandom_range(0, 4) == 0) ? 40 : 12;
            burst = $urandom_range(1, cap);
            for (int i = 0; i < burst && sent < 115; i++) begin
               send_frame(random_pulse(), random_pulse(), random_pulse(), random_pulse());
               sent++;
            end
            if ($urandom_range(0, 3) != 0) begin
               req_tvalid <= 1'b0;
               repeat ($urandom_range(1, 6)) @(posedge clock);
            end
         end
         wait_for_quiet();
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_deadband_limits();
      test_random_traffic();
      wait_for_quiet();
      $display("covered %0d frames and %0d commands over %0d register settings",
               frames_sent, commands_seen, settings_used);
      $display("corners: clamps, deadband edges, saturated bands, zero and full gains");
      if (mismatches == 0) begin
         $display("** rc_stick_command_shaper_unit: PASSED **");
      end else begin
         $display("** rc_stick_command_shaper_unit: FAILED **");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout with %0d commands outstanding", pending_commands.size());
      $display("** rc_stick_command_shaper_unit: FAILED **");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/rcs_pkg.sv
rtl/rc_stick_command_shaper_unit.sv
bench/rc_stick_command_shaper_unit_tb.sv
